[sv/wstm_pkg.sv]
package wstm_pkg;

    localparam int VALUE_W     = 16;
    localparam int TARGET_W    = 20;
    localparam int SUM_W       = 21;
    localparam int VERSE_W     = 16;
    localparam int INDEX_W     = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [TARGET_W-1:0] TARGET_RESET = 20'd1;

    typedef struct packed {
        logic store;
        logic verse_end;
    } word_tag_t;

    typedef enum logic {
        ST_IDLE,
        ST_TRIM
    } back_state_t;

endpackage

[sv/wstm_ifs.sv]
interface wstm_in_if;
    import wstm_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] word_value;
    logic               verse_end;

    modport source (output valid, word_value, verse_end, input ready);
    modport sink (input valid, word_value, verse_end, output ready);
endinterface

interface wstm_out_if;
    import wstm_pkg::*;

    logic               valid;
    logic               ready;
    logic [VERSE_W-1:0] verse_number;
    logic [INDEX_W-1:0] first_word;
    logic [INDEX_W-1:0] last_word;

    modport source (output valid, verse_number, first_word, last_word, input ready);
    modport sink (input valid, verse_number, first_word, last_word, output ready);
endinterface

interface wstm_cfg_if;
    import wstm_pkg::*;

    logic                valid;
    logic                ready;
    logic [TARGET_W-1:0] target_sum;

    modport source (output valid, target_sum, input ready);
    modport sink (input valid, target_sum, output ready);
endinterface

[sv/wstm_queue.sv]
module wstm_queue #(
    parameter int W = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);
    import wstm_pkg::*;

    logic [W-1:0]      slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[sv/wstm_front.sv]
module wstm_front #(
    parameter int MAX_WORDS = 64
) (
    input  logic                                                     clk,
    input  logic                                                     rst_n,
    input  logic                                                     in_valid,
    output logic                                                     in_ready,
    input  logic [wstm_pkg::VALUE_W-1:0]                             word_value,
    input  logic                                                     verse_end,
    output logic                                                     q_valid,
    input  logic                                                     q_ready,
    output logic [$bits(wstm_pkg::word_tag_t)+$clog2(MAX_WORDS)+wstm_pkg::VALUE_W-1:0] q_data
);
    import wstm_pkg::*;

    localparam int IW = $clog2(MAX_WORDS);

    logic [IW:0] pos_reg;
    logic [IW:0] pos_next;
    word_tag_t   tag;
    logic        accept;

    assign in_ready  = q_ready;
    assign q_valid   = in_valid;
    assign accept    = in_valid && q_ready;

    // Words beyond the window capacity are tagged so the back end only applies the verse end.
    assign tag.store     = (pos_reg < (IW+1)'(MAX_WORDS));
    assign tag.verse_end = verse_end;
    assign q_data        = {tag, pos_reg[IW-1:0], word_value};

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            if (verse_end)
            begin
                pos_next = '0;
            end
            else if (tag.store)
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

[sv/wstm_back.sv]
module wstm_back #(
    parameter int MAX_WORDS = 64
) (
    input  logic                                                     clk,
    input  logic                                                     rst_n,
    input  logic                                                     cfg_valid,
    input  logic [wstm_pkg::TARGET_W-1:0]                            cfg_data,
    input  logic                                                     q_valid,
    output logic                                                     q_ready,
    input  logic [$bits(wstm_pkg::word_tag_t)+$clog2(MAX_WORDS)+wstm_pkg::VALUE_W-1:0] q_data,
    output logic                                                     out_valid,
    input  logic                                                     out_ready,
    output logic [wstm_pkg::VERSE_W-1:0]                             verse_number,
    output logic [wstm_pkg::INDEX_W-1:0]                             first_word,
    output logic [wstm_pkg::INDEX_W-1:0]                             last_word
);
    import wstm_pkg::*;

    localparam int IW = $clog2(MAX_WORDS);

    logic [VALUE_W-1:0]  mem [MAX_WORDS];
    logic [VALUE_W-1:0]  head_reg;

    back_state_t         state_reg;
    back_state_t         state_next;
    logic [TARGET_W-1:0] target_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [IW:0]         start_reg;
    logic [IW:0]         start_next;
    logic [IW-1:0]       cur_reg;
    logic [IW-1:0]       cur_next;
    logic                vend_reg;
    logic                vend_next;
    logic [VERSE_W-1:0]  verse_reg;
    logic [VERSE_W-1:0]  verse_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [VERSE_W-1:0]  out_verse_reg;
    logic [INDEX_W-1:0]  out_first_reg;
    logic [INDEX_W-1:0]  out_last_reg;
    logic                load_out;

    word_tag_t           q_tag;
    logic [IW-1:0]       q_idx;
    logic [VALUE_W-1:0]  q_value;
    logic                wr_en;
    logic                in_window;
    logic                over;
    logic                match;
    logic                out_busy;
    logic [IW+INDEX_W:0] first_ext;
    logic [IW+INDEX_W-1:0] last_ext;

    assign q_tag   = q_data[$bits(word_tag_t)+IW+VALUE_W-1 -: $bits(word_tag_t)];
    assign q_idx   = q_data[IW+VALUE_W-1 -: IW];
    assign q_value = q_data[VALUE_W-1:0];

    assign in_window = (start_reg <= {1'b0, cur_reg});
    assign over      = (sum_reg > {1'b0, target_reg});
    assign match     = in_window && (sum_reg == {1'b0, target_reg});
    assign out_busy  = out_valid_reg && !out_ready;

    assign first_ext = {{INDEX_W{1'b0}}, start_reg};
    assign last_ext  = {{INDEX_W{1'b0}}, cur_reg};

    always_comb
    begin
        state_next = state_reg;
        sum_next   = sum_reg;
        start_next = start_reg;
        cur_next   = cur_reg;
        vend_next  = vend_reg;
        verse_next = verse_reg;
        q_ready    = 1'b0;
        wr_en      = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    if (q_tag.store)
                    begin
                        wr_en      = 1'b1;
                        sum_next   = sum_reg + {{(SUM_W-VALUE_W){1'b0}}, q_value};
                        cur_next   = q_idx;
                        vend_next  = q_tag.verse_end;
                        state_next = ST_TRIM;
                    end
                    else if (q_tag.verse_end)
                    begin
                        sum_next   = '0;
                        start_next = '0;
                        verse_next = verse_reg + 1'b1;
                    end
                end
            end
            ST_TRIM:
            begin
                if (over && in_window)
                begin
                    sum_next   = sum_reg - {{(SUM_W-VALUE_W){1'b0}}, head_reg};
                    start_next = start_reg + 1'b1;
                end
                else if (!(match && out_busy))
                begin
                    load_out   = match;
                    state_next = ST_IDLE;
                    if (vend_reg)
                    begin
                        sum_next   = '0;
                        start_next = '0;
                        verse_next = verse_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // The head register always holds the window entry at start_reg, including a same-cycle write.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[q_idx] <= q_value;
        end
        if (wr_en && (q_idx == start_next[IW-1:0]))
        begin
            head_reg <= q_value;
        end
        else
        begin
            head_reg <= mem[start_next[IW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_verse_reg <= verse_reg;
            out_first_reg <= first_ext[INDEX_W-1:0];
            out_last_reg  <= last_ext[INDEX_W-1:0];
        end
        cur_reg  <= cur_next;
        vend_reg <= vend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            target_reg    <= TARGET_RESET;
            sum_reg       <= '0;
            start_reg     <= '0;
            verse_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            start_reg     <= start_next;
            verse_reg     <= verse_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                target_reg <= cfg_data;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign verse_number = out_verse_reg;
    assign first_word   = out_first_reg;
    assign last_word    = out_last_reg;

endmodule

[sv/window_sum_target_match.sv]
// Finds runs of consecutive words inside one verse whose values add up to target_sum.
// word_in carries one word per beat: its value and a flag that marks the last word of a verse.
// match_out carries one beat per match: the verse number and the first and last word index.
// cfg carries a new target_sum; it is always ready and must only be written while idle.
// A beat on word_in enters a four-entry queue, so words keep arriving while the trimming
// engine works or while a match waits in the output register.
// A stored word is added to the sum in the idle state; the trimming state then drops words
// from the front of the window, one per cycle through the window memory read port, and the
// engine takes no new word until it returns to idle. Words past MAX_WORDS in a verse are
// consumed in the idle state. Each word is added once and dropped at most once.
// A match is loaded into the output register from the trimming state once trimming ends.
// When match_out is stalled the result holds, the engine waits before loading a second match,
// and word_in.ready goes low once the queue is full.
// Reset empties the queue and window, clears the verse counter and sets target_sum to 1.
// The window memory itself is not cleared; only entries written in the current verse are read.
module window_sum_target_match #(
    parameter int MAX_WORDS = 64
) (
    input logic       clk,
    input logic       rst_n,
    wstm_in_if.sink   word_in,
    wstm_out_if.source match_out,
    wstm_cfg_if.sink  cfg
);
    import wstm_pkg::*;

    localparam int ENTRY_W = $bits(word_tag_t) + $clog2(MAX_WORDS) + VALUE_W;

    logic               fq_valid;
    logic               fq_ready;
    logic [ENTRY_W-1:0] fq_data;
    logic               qb_valid;
    logic               qb_ready;
    logic [ENTRY_W-1:0] qb_data;

    assign cfg.ready = 1'b1;

    wstm_front #(
        .MAX_WORDS (MAX_WORDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (word_in.valid),
        .in_ready   (word_in.ready),
        .word_value (word_in.word_value),
        .verse_end  (word_in.verse_end),
        .q_valid    (fq_valid),
        .q_ready    (fq_ready),
        .q_data     (fq_data)
    );

    wstm_queue #(
        .W (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    wstm_back #(
        .MAX_WORDS (MAX_WORDS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg.valid),
        .cfg_data     (cfg.target_sum),
        .q_valid      (qb_valid),
        .q_ready      (qb_ready),
        .q_data       (qb_data),
        .out_valid    (match_out.valid),
        .out_ready    (match_out.ready),
        .verse_number (match_out.verse_number),
        .first_word   (match_out.first_word),
        .last_word    (match_out.last_word)
    );

endmodule
